@@ design/wta_pkg.sv @@
`default_nettype none
package wta_pkg;

	localparam int TIME_W  = 24;
	localparam int SUM_W   = 31;
	localparam int CNT_W   = 7;
	localparam int FRAME_W = 3;
	localparam int CH_N    = 4;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [FRAME_W-1:0] frame_t;

	typedef time_t [CH_N-1:0] time_vec_t;
	typedef sum_t  [CH_N-1:0] sum_vec_t;

endpackage
`default_nettype wire

@@ design/windowed_timing_average.sv @@
`default_nettype none
// Boxcar moving average of four frame timings (total, preprocess, inference,
// postprocess; unsigned 24-bit, 1/256 ms). After reset or a request with
// restart set, the first WARMUP frames only count; later frames enter four
// windows of WINDOW samples kept in one on-chip memory, with a running sum per
// channel. Every request returns one result: stable, fill_count and the four
// truncated means (zero while the window is empty). One request occupies the
// block through these steps: the accepting cycle, which issues the ring read,
// the sum update, the divider load, 31 steps of the bit-serial divider that
// serves all four channels at once plus a state to report done, and the output
// load. The next request can be taken once the output register is loaded. A
// finished result waits in the output register while the next request is
// taken; a second result waits until the first is taken. No clearing pass
// runs after reset; the block is ready at once.
module windowed_timing_average #(
	parameter int WARMUP = 5,
	parameter int WINDOW = 100
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   restart,
	input  wire wta_pkg::time_t         total_time,
	input  wire wta_pkg::time_t         prep_time,
	input  wire wta_pkg::time_t         infer_time,
	input  wire wta_pkg::time_t         post_time,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        stable,
	output wta_pkg::cnt_t               fill_count,
	output wta_pkg::time_t              avg_total,
	output wta_pkg::time_t              avg_prep,
	output wta_pkg::time_t              avg_infer,
	output wta_pkg::time_t              avg_post
);
	import wta_pkg::*;

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t    state_q;
	frame_t    frames_q;
	logic [AW-1:0] slot_q;
	cnt_t      held_q;
	sum_vec_t  sums_q;
	time_vec_t sample_q;
	logic      stable_q;

	logic      out_valid_q;
	logic      out_stable_q;
	cnt_t      out_fill_q;
	time_vec_t out_avg_q;

	logic      accept;
	frame_t    frames_base;
	frame_t    frames_next;
	logic      full;
	logic [AW-1:0] slot_next;
	time_vec_t sample_in;
	time_vec_t ring_old;
	logic      ring_wr;
	logic      div_start;
	logic      div_done;
	sum_vec_t  quot;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign sample_in = {post_time, infer_time, prep_time, total_time};

	assign frames_base = restart ? '0 : frames_q;
	assign frames_next = (frames_base <= FRAME_W'(WARMUP)) ? frames_base + 1'b1 : frames_base;
	assign full        = (held_q == CNT_W'(WINDOW));
	assign slot_next   = (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
	assign ring_wr     = (state_q == ST_UPD) && stable_q;
	assign div_start   = (state_q == ST_LOAD);

	// the read issued at acceptance completes before the write in the update
	// cycle, so read and write of one slot never overlap
	wta_ring #(
		.DEPTH (WINDOW),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_wr),
		.wr_addr (slot_q),
		.wr_data (sample_q),
		.rd_en   (accept),
		.rd_addr (restart ? '0 : slot_q),
		.rd_data (ring_old)
	);

	wta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sums_q),
		.divisor  (held_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frames_q     <= '0;
			slot_q       <= '0;
			held_q       <= '0;
			sums_q       <= '0;
			sample_q     <= '0;
			stable_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_stable_q <= 1'b0;
			out_fill_q   <= '0;
			out_avg_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sample_q <= sample_in;
						frames_q <= frames_next;
						stable_q <= (frames_next > FRAME_W'(WARMUP));
						if (restart) begin
							slot_q <= '0;
							held_q <= '0;
							sums_q <= '0;
						end
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (stable_q) begin
						for (int c = 0; c < CH_N; c++) begin
							sums_q[c] <= sums_q[c] + SUM_W'(sample_q[c])
								- (full ? SUM_W'(ring_old[c]) : '0);
						end
						if (!full) begin
							held_q <= held_q + 1'b1;
						end
						slot_q <= slot_next;
					end
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the previous result is taken
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_stable_q <= stable_q;
						out_fill_q   <= held_q;
						for (int c = 0; c < CH_N; c++) begin
							out_avg_q[c] <= (held_q == '0) ? '0 : quot[c][TIME_W-1:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign stable     = out_stable_q;
	assign fill_count = out_fill_q;
	assign avg_total  = out_avg_q[0];
	assign avg_prep   = out_avg_q[1];
	assign avg_infer  = out_avg_q[2];
	assign avg_post   = out_avg_q[3];

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(WINDOW))
		else $error("fill count exceeds window");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < AW'(WINDOW))
		else $error("write slot out of range");

	a_stable_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stable) |-> (fill_count != '0))
		else $error("stable result with empty window");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_DIV) && !div_done)
		else $error("divider finished too early");
`endif

endmodule
`default_nettype wire

@@ design/wta_ring.sv @@
`default_nettype none
module wta_ring #(
	parameter int DEPTH = 100,
	parameter int AW    = 7
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire wta_pkg::time_vec_t   wr_data,
	input  wire logic                 rd_en,
	input  wire logic [AW-1:0]        rd_addr,
	output wta_pkg::time_vec_t        rd_data
);
	import wta_pkg::*;

	time_vec_t mem [DEPTH];
	time_vec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

@@ design/wta_div.sv @@
`default_nettype none
module wta_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire wta_pkg::sum_vec_t  dividend,
	input  wire wta_pkg::cnt_t      divisor,
	output logic                    done,
	output wta_pkg::sum_vec_t       quotient
);
	import wta_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	cnt_t              div_q;
	sum_vec_t          dvd_q;
	cnt_t [CH_N-1:0]   rem_q;

	logic [CNT_W:0]    trial [CH_N];
	logic [CH_N-1:0]   ge;

	// one restoring step per lane, all lanes share the divisor
	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			trial[c] = {rem_q[c], dvd_q[c][SUM_W-1]};
			ge[c]    = trial[c] >= {1'b0, div_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			for (int c = 0; c < CH_N; c++) begin
				rem_q[c] <= ge[c] ? CNT_W'(trial[c] - {1'b0, div_q}) : trial[c][CNT_W-1:0];
				dvd_q[c] <= {dvd_q[c][SUM_W-2:0], ge[c]};
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

@@ bench/tb_windowed_timing_average.sv @@
`timescale 1ns / 100ps

module tb_windowed_timing_average;
	import wta_pkg::*;

	localparam int WARMUP = 5;
	localparam int WINDOW = 100;
	localparam time_t TIME_MAX = '1;
	localparam int FIFO_DEPTH = 2048;

	typedef struct {
		logic      restart;
		time_vec_t times;   // 0 total, 1 prep, 2 infer, 3 post
	} request_t;

	typedef struct {
		logic      stable;
		cnt_t      fill;
		time_vec_t avg;
	} means_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	logic  restart;
	time_t total_time;
	time_t prep_time;
	time_t infer_time;
	time_t post_time;
	logic  out_valid;
	logic  out_ready;
	logic  stable;
	cnt_t  fill_count;
	time_t avg_total;
	time_t avg_prep;
	time_t avg_infer;
	time_t avg_post;

	windowed_timing_average #(
		.WARMUP(WARMUP),
		.WINDOW(WINDOW)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.total_time(total_time),
		.prep_time (prep_time),
		.infer_time(infer_time),
		.post_time (post_time),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stable    (stable),
		.fill_count(fill_count),
		.avg_total (avg_total),
		.avg_prep  (avg_prep),
		.avg_infer (avg_infer),
		.avg_post  (avg_post)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Window state of the averaging predictor
	frame_t    seen_frames = '0;
	cnt_t      next_slot   = '0;
	cnt_t      held_frames = '0;
	time_t     window_mem [CH_N][WINDOW];
	sum_vec_t  window_sum  = '0;

	// Pending requests and expected results, kept as rings with running counters
	request_t  req_fifo [FIFO_DEPTH];
	int        req_wr = 0;
	int        req_rd = 0;
	means_t    exp_fifo [FIFO_DEPTH];
	int        exp_wr = 0;
	int        exp_rd = 0;

	bit        sender_gaps   = 1'b1;
	bit        receiver_gaps = 1'b1;
	int        hold_request  = 0;
	int        hold_left     = 0;
	int        stall_left    = 0;

	int        error_count   = 0;
	int        frames_sent   = 0;
	int        restarts_sent = 0;
	int        full_frames   = 0;
	int        results_seen  = 0;
	int        stable_seen   = 0;

	function automatic means_t predict_means(input logic restart_bit, input time_vec_t smp);
		means_t m;
		cnt_t   slot;
		logic   full;
		int     ch;
		if (restart_bit) begin
			seen_frames = '0;
			next_slot   = '0;
			held_frames = '0;
			window_sum  = '0;
		end
		if (seen_frames <= WARMUP)
			seen_frames = seen_frames + 1'b1;
		m.stable = 1'b0;
		if (seen_frames > WARMUP) begin
			slot = (next_slot >= WINDOW) ? cnt_t'(0) : next_slot;
			full = (held_frames >= WINDOW);
			// add the new sample, drop the oldest once the window is full
			for (ch = 0; ch < CH_N; ch++) begin
				window_sum[ch] = window_sum[ch] + smp[ch];
				if (full)
					window_sum[ch] = window_sum[ch] - window_mem[ch][slot];
				window_mem[ch][slot] = smp[ch];
			end
			if (full)
				full_frames++;
			else
				held_frames = held_frames + 1'b1;
			slot = slot + 1'b1;
			next_slot = (slot >= WINDOW) ? cnt_t'(0) : slot;
			m.stable = 1'b1;
		end
		m.fill = held_frames;
		for (ch = 0; ch < CH_N; ch++)
			m.avg[ch] = (held_frames == 0) ? time_t'(0) : time_t'(window_sum[ch] / held_frames);
		return m;
	endfunction

	function automatic time_t pick_time();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return TIME_MAX;
			2, 3: return time_t'($urandom_range(0, 255));
			default: return time_t'($urandom);
		endcase
	endfunction

	task automatic queue_frame(input logic restart_bit, input time_vec_t smp);
		request_t f;
		f.restart = restart_bit;
		f.times   = smp;
		req_fifo[req_wr % FIFO_DEPTH] = f;
		req_wr++;
	endtask

	task automatic queue_random(input int count, input int restart_odds);
		time_vec_t smp;
		int        n;
		int        ch;
		for (n = 0; n < count; n++) begin
			for (ch = 0; ch < CH_N; ch++)
				smp[ch] = pick_time();
			queue_frame($urandom_range(1, restart_odds) == 1, smp);
		end
	endtask

	// Offer every queued request; valid stays up between back-to-back requests
	task automatic play_frames();
		request_t f;
		int       gap;
		while (req_wr - req_rd > 0) begin
			f = req_fifo[req_rd % FIFO_DEPTH];
			req_rd++;
			if (sender_gaps && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 11);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid   <= 1'b1;
			restart    <= f.restart;
			total_time <= f.times[0];
			prep_time  <= f.times[1];
			infer_time <= f.times[2];
			post_time  <= f.times[3];
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			exp_fifo[exp_wr % FIFO_DEPTH] = predict_means(f.restart, f.times);
			exp_wr++;
			frames_sent++;
			if (f.restart)
				restarts_sent++;
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] expv,
		input logic [31:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
			error_count++;
		end
	endtask

	// Result side: check accepted results, then pick next ready
	always @(posedge clk) begin
		means_t    m;
		time_vec_t got;
		int        ch;
		if (out_valid && out_ready) begin
			results_seen++;
			if (stable)
				stable_seen++;
			if (exp_wr == exp_rd) begin
				$display("%0t: result with no request pending, expected none, actual fill %0d",
					$time, fill_count);
				error_count++;
			end else begin
				m = exp_fifo[exp_rd % FIFO_DEPTH];
				exp_rd++;
				got = {avg_post, avg_infer, avg_prep, avg_total};
				compare_field("stable", 32'(m.stable), 32'(stable));
				compare_field("fill_count", 32'(m.fill), 32'(fill_count));
				for (ch = 0; ch < CH_N; ch++)
					compare_field($sformatf("avg[%0d]", ch), 32'(m.avg[ch]), 32'(got[ch]));
			end
		end
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Warmup, extremes, bit patterns and restarts in and after warmup
	task automatic test_directed();
		int n;
		for (n = 0; n < WARMUP; n++)
			queue_frame(1'b0, (n % 2) ? '0 : {CH_N{TIME_MAX}});
		queue_frame(1'b0, {CH_N{TIME_MAX}});
		queue_frame(1'b0, '0);
		queue_frame(1'b0, {24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555});
		queue_frame(1'b0, {24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA});
		queue_frame(1'b0, {24'h000001, 24'h800000, 24'h7FFFFF, 24'hFFFFFE});
		// restart on a stable stream, then again inside warmup
		queue_frame(1'b1, {CH_N{TIME_MAX}});
		queue_frame(1'b0, '0);
		queue_frame(1'b1, {24'h123456, 24'h0, 24'hFFFFFF, 24'h000100});
		for (n = 0; n < WARMUP + 3; n++)
			queue_frame(1'b0, {time_t'(n * 3), time_t'(n), TIME_MAX, time_t'(n * 7)});
		play_frames();
		wait_drained();
	endtask

	// Fill the window at full scale to reach the largest sums, then flush with zeros
	task automatic test_full_scale();
		int n;
		queue_frame(1'b1, {CH_N{TIME_MAX}});
		for (n = 0; n < WARMUP + WINDOW + 10; n++)
			queue_frame(1'b0, {CH_N{TIME_MAX}});
		for (n = 0; n < 25; n++)
			queue_frame(1'b0, '0);
		play_frames();
		wait_drained();
	endtask

	task automatic test_random_traffic();
		queue_random(1000, 300);
		play_frames();
		wait_drained();
	endtask

	// Hold off the receiver long enough that the block backs up its input
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		@(negedge clk);
		hold_request = 500;
		@(posedge clk);
		queue_random(40, 30);
		play_frames();
		wait_drained();
		sender_gaps = 1'b1;
	endtask

	task automatic test_no_idle();
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		queue_random(280, 200);
		play_frames();
		wait_drained();
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		out_ready  <= 1'b0;
		restart    <= 1'b0;
		total_time <= '0;
		prep_time  <= '0;
		infer_time <= '0;
		post_time  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_scale();
		test_random_traffic();
		test_backpressure();
		test_no_idle();

		if (exp_wr != exp_rd)
			error_count++;
		$display("Run covered %0d frames (%0d restarts): %0d results checked, %0d stable.",
			frames_sent, restarts_sent, results_seen, stable_seen);
		$display("%0d frames replaced the oldest entry of a full window; %0d errors.",
			full_frames, error_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d results outstanding", exp_wr - exp_rd);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
